// ===== src/dgf_pkg.sv =====
`timescale 1ns / 1ps

package dgf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_COUNT     = 7;
  localparam int ADDR_W        = 3;
  localparam int CFG_W         = 32;
  localparam int ANGLE_W       = 18;
  localparam int CUT_W         = 31;
  localparam int SUM_W         = 48;

  localparam logic [ADDR_W-1:0] REG_BURGERS_RE = 3'd0;
  localparam logic [ADDR_W-1:0] REG_BURGERS_IM = 3'd1;
  localparam logic [ADDR_W-1:0] REG_TARGET_X   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_TARGET_Y   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_CUTOFF     = 3'd4;
  localparam logic [ADDR_W-1:0] REG_COS_TWO    = 3'd5;
  localparam logic [ADDR_W-1:0] REG_SIN_TWO    = 3'd6;

  // glide constant 0.07/(8*pi*(1-0.09)) in Q0.32
  localparam logic signed [63:0] GLIDE_K = 64'sd13145486;
  localparam logic signed [63:0] INT_LIM = 64'sd2305843009213693951;
  localparam logic signed [SUM_W-1:0] SUM_LIM = 48'sd140737488355327;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } alu_state_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic        neg;
    logic [5:0]  k;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } alu_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CHK,
    ST_DSQX, ST_DSQY, ST_CSQ,
    ST_NSQX, ST_NSQY, ST_NXY,
    ST_WX, ST_WY, ST_EX, ST_EY,
    ST_FBR, ST_FBI, ST_R1, ST_R2,
    ST_G1, ST_G2, ST_G3, ST_G4,
    ST_FGR, ST_FGI,
    ST_P1, ST_P2, ST_P3, ST_P4,
    ST_ACC,
    ST_K1, ST_K2, ST_FX, ST_FY,
    ST_EMIT
  } seq_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp_int(input logic signed [65:0] v);
    if (v > 66'(INT_LIM)) begin
      clamp_int = INT_LIM;
    end else if (v < -66'(INT_LIM)) begin
      clamp_int = -INT_LIM;
    end else begin
      clamp_int = 64'(v);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] sum_add(input logic signed [SUM_W-1:0] acc,
                                                      input logic signed [63:0] v);
    logic signed [65:0] s;
    s = 66'(acc) + 66'(v);
    if (s > 66'(SUM_LIM)) begin
      sum_add = SUM_LIM;
    end else if (s < -66'(SUM_LIM)) begin
      sum_add = -SUM_LIM;
    end else begin
      sum_add = SUM_W'(s);
    end
  endfunction

  function automatic alu_req_t mul_req(input logic signed [63:0] a,
                                       input logic signed [63:0] b,
                                       input logic [5:0] k);
    alu_req_t r;
    r.start = 1'b0;
    r.op    = ALU_MUL;
    r.neg   = a[63] ^ b[63];
    r.k     = k;
    r.a     = mag64(a);
    r.b     = mag64(b);
    mul_req = r;
  endfunction

  function automatic alu_req_t div_req(input logic [63:0] num, input logic [5:0] k,
                                       input logic [63:0] den, input logic neg);
    alu_req_t r;
    r.start = 1'b0;
    r.op    = ALU_DIV;
    r.neg   = neg;
    r.k     = k;
    r.a     = num;
    r.b     = den;
    div_req = r;
  endfunction

endpackage

// ===== src/dgf_alu.sv =====
`timescale 1ns / 1ps

module dgf_alu #(
  parameter int FRAC_BITS = dgf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dgf_pkg::alu_req_t req,
  output dgf_pkg::alu_rsp_t rsp
);

  localparam int NW  = 64 + 2 * FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);

  dgf_pkg::alu_state_t st_r, st_nxt;
  dgf_pkg::alu_op_t    op_r;
  logic [127:0]        acc_r;
  logic [127:0]        ash_r;
  logic [63:0]         b_r;
  logic [5:0]          k_r;
  logic                neg_r;
  logic [NW-1:0]       num_r;
  logic [NW-1:0]       q_r;
  logic [63:0]         rem_r;
  logic [63:0]         den_r;
  logic [CW-1:0]       cnt_r;
  logic                done_r;
  logic signed [63:0]  res_r;

  logic [64:0]         trial;
  logic                qbit;
  logic [127:0]        rnd;
  logic [63:0]         mag;

  assign trial = {rem_r, num_r[NW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    rnd = (acc_r + ((128'(1) << k_r) >> 1)) >> k_r;
    if (op_r == dgf_pkg::ALU_DIV) begin
      mag = (q_r > NW'(dgf_pkg::INT_LIM)) ? 64'(dgf_pkg::INT_LIM) : q_r[63:0];
    end else if (k_r == 6'd0) begin
      mag = acc_r[63:0];
    end else begin
      mag = (rnd > 128'(dgf_pkg::INT_LIM)) ? 64'(dgf_pkg::INT_LIM) : rnd[63:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dgf_pkg::A_IDLE: begin
        if (req.start) begin
          st_nxt = (req.op == dgf_pkg::ALU_DIV) ? dgf_pkg::A_DIV : dgf_pkg::A_MUL;
        end
      end
      dgf_pkg::A_MUL: begin
        if (b_r == 64'd0) begin
          st_nxt = dgf_pkg::A_FIN;
        end
      end
      dgf_pkg::A_DIV: begin
        if (cnt_r == CW'(1)) begin
          st_nxt = dgf_pkg::A_FIN;
        end
      end
      dgf_pkg::A_FIN: st_nxt = dgf_pkg::A_IDLE;
      default: st_nxt = dgf_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= dgf_pkg::A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == dgf_pkg::A_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      dgf_pkg::A_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          k_r   <= req.k;
          neg_r <= req.neg;
          acc_r <= '0;
          ash_r <= {64'd0, req.a};
          b_r   <= req.b;
          den_r <= req.b;
          num_r <= NW'(req.a) << req.k;
          rem_r <= '0;
          q_r   <= '0;
          cnt_r <= CW'(NW);
        end
      end
      dgf_pkg::A_MUL: begin
        if (b_r[0]) begin
          acc_r <= acc_r + ash_r;
        end
        ash_r <= ash_r << 1;
        b_r   <= b_r >> 1;
      end
      dgf_pkg::A_DIV: begin
        // restoring step, one quotient bit per cycle
        rem_r <= qbit ? 64'(trial - {1'b0, den_r}) : trial[63:0];
        q_r   <= {q_r[NW-2:0], qbit};
        num_r <= num_r << 1;
        cnt_r <= cnt_r - CW'(1);
      end
      dgf_pkg::A_FIN: begin
        res_r <= neg_r ? -$signed(mag) : $signed(mag);
      end
      default: begin
      end
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== src/dislocation_glide_force_unit.sv =====
`timescale 1ns / 1ps
// one item per input handshake; in_tready is high only while the sequencer is idle
// a non-source, non-last item keeps the sequencer idle; a last item adds 4 products plus the hand-off
// a counted source runs up to 20 products and 4 divisions on one shared unit:
//   product: steps over the bits of the second operand; division: 64 + 2*FRAC_BITS quotient bits
// rst_n is synchronous, active low: clears stress sums, output valid, sequencer, registers to defaults
module dislocation_glide_force_unit #(
  parameter int FRAC_BITS = dgf_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // point_x, point_y
  input  logic                       in_tuser,   // is_source
  input  logic                       in_tlast,   // last_point
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // force_x, force_y
  input  logic                       cfg_we,
  input  logic [dgf_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [dgf_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam logic [5:0] KF   = 6'(FRAC_BITS);
  localparam logic [5:0] KF1  = 6'(FRAC_BITS + 1);
  localparam logic [5:0] K2F  = 6'(2 * FRAC_BITS);
  localparam logic [5:0] KQ32 = 6'd32;

  // configuration
  logic signed [31:0]                  br_r, bi_r, tx_r, ty_r;
  logic [dgf_pkg::CUT_W-1:0]           cut_r;
  logic signed [dgf_pkg::ANGLE_W-1:0]  cos2_r, sin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r   <= '0;
      bi_r   <= '0;
      tx_r   <= '0;
      ty_r   <= '0;
      cut_r  <= '0;
      cos2_r <= dgf_pkg::ANGLE_W'(64'd1 << FRAC_BITS);
      sin2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dgf_pkg::REG_BURGERS_RE: br_r   <= cfg_wdata;
        dgf_pkg::REG_BURGERS_IM: bi_r   <= cfg_wdata;
        dgf_pkg::REG_TARGET_X:   tx_r   <= cfg_wdata;
        dgf_pkg::REG_TARGET_Y:   ty_r   <= cfg_wdata;
        dgf_pkg::REG_CUTOFF:     cut_r  <= cfg_wdata[dgf_pkg::CUT_W-1:0];
        dgf_pkg::REG_COS_TWO:    cos2_r <= cfg_wdata[dgf_pkg::ANGLE_W-1:0];
        dgf_pkg::REG_SIN_TWO:    sin2_r <= cfg_wdata[dgf_pkg::ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dgf_pkg::seq_state_t st_r, st_nxt;
  logic                issued_r, issued_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                emit;
  logic                cap;
  dgf_pkg::alu_req_t   req, op;
  dgf_pkg::alu_rsp_t   rsp;
  dgf_pkg::seq_state_t op_next;
  logic                is_op;

  logic signed [31:0]  px_r, py_r;
  logic                last_r;
  logic [63:0]         sqx_r, sqy_r, nxy_r;
  logic signed [63:0]  wx_r, wy_r, ex_r, ey_r, fbr_r, fbi_r, t1_r, rephi_r;
  logic signed [63:0]  gr_r, gi_r, fgr_r, fgi_r, p_r, q_r, kf_r;
  logic signed [31:0]  fx_r, fy_r, ox_r, oy_r;
  logic signed [dgf_pkg::SUM_W-1:0] xx_r, yy_r, xy_r;

  // target offset and its scaled magnitudes
  logic signed [32:0]  dx, dy;
  logic [32:0]         ax, ay;
  logic [1:0]          sh;
  logic [30:0]         nx, ny;
  logic                far;
  logic [63:0]         n2;
  logic [63:0]         csq_sum;
  logic signed [63:0]  two;
  logic signed [dgf_pkg::SUM_W:0] ydiff;
  dgf_pkg::seq_state_t skip_st;

  assign dx      = 33'(tx_r) - 33'(px_r);
  assign dy      = 33'(ty_r) - 33'(py_r);
  assign ax      = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay      = dy[32] ? 33'(-dy) : 33'(dy);
  assign sh      = (ax[32] | ay[32]) ? 2'd2 : ((ax[31] | ay[31]) ? 2'd1 : 2'd0);
  assign nx      = 31'(ax >> sh);
  assign ny      = 31'(ay >> sh);
  assign far     = (ax > 33'(cut_r)) || (ay > 33'(cut_r));
  assign n2      = sqx_r + sqy_r;
  assign csq_sum = sqx_r + sqy_r;
  assign two     = dgf_pkg::clamp_int(66'(rephi_r) <<< 1);
  assign ydiff   = (dgf_pkg::SUM_W+1)'(yy_r) - (dgf_pkg::SUM_W+1)'(xx_r);
  assign skip_st = last_r ? dgf_pkg::ST_K1 : dgf_pkg::ST_IDLE;
  assign cap     = issued_r & rsp.done;

  // operands and successor of each step on the shared unit
  always_comb begin
    op      = '0;
    op_next = dgf_pkg::ST_IDLE;
    is_op   = 1'b1;
    unique case (st_r)
      dgf_pkg::ST_DSQX: begin
        op = dgf_pkg::mul_req(64'(ax), 64'(ax), 6'd0);  op_next = dgf_pkg::ST_DSQY;
      end
      dgf_pkg::ST_DSQY: begin
        op = dgf_pkg::mul_req(64'(ay), 64'(ay), 6'd0);  op_next = dgf_pkg::ST_CSQ;
      end
      dgf_pkg::ST_CSQ: begin
        op = dgf_pkg::mul_req(64'(cut_r), 64'(cut_r), 6'd0);
        op_next = (csq_sum > 64'(rsp.result)) ? dgf_pkg::ST_NSQX : skip_st;
      end
      dgf_pkg::ST_NSQX: begin
        op = dgf_pkg::mul_req(64'(nx), 64'(nx), 6'd0);  op_next = dgf_pkg::ST_NSQY;
      end
      dgf_pkg::ST_NSQY: begin
        op = dgf_pkg::mul_req(64'(ny), 64'(ny), 6'd0);
        op_next = ((sqx_r + 64'(rsp.result)) == 64'd0) ? skip_st : dgf_pkg::ST_NXY;
      end
      dgf_pkg::ST_NXY: begin
        op = dgf_pkg::mul_req(64'(nx), 64'(ny), 6'd0);  op_next = dgf_pkg::ST_WX;
      end
      dgf_pkg::ST_WX: begin
        op = dgf_pkg::div_req(64'(nx), K2F - 6'(sh), n2, dx[32]);
        op_next = dgf_pkg::ST_WY;
      end
      dgf_pkg::ST_WY: begin
        op = dgf_pkg::div_req(64'(ny), K2F - 6'(sh), n2, dy[32]);
        op_next = dgf_pkg::ST_EX;
      end
      dgf_pkg::ST_EX: begin
        op = dgf_pkg::div_req((sqx_r >= sqy_r) ? sqx_r - sqy_r : sqy_r - sqx_r, KF, n2,
                              sqx_r < sqy_r);
        op_next = dgf_pkg::ST_EY;
      end
      dgf_pkg::ST_EY: begin
        op = dgf_pkg::div_req(nxy_r << 1, KF, n2, dx[32] ^ dy[32]);
        op_next = dgf_pkg::ST_FBR;
      end
      dgf_pkg::ST_FBR: begin
        op = dgf_pkg::mul_req(64'(br_r), dgf_pkg::GLIDE_K, KQ32);  op_next = dgf_pkg::ST_FBI;
      end
      dgf_pkg::ST_FBI: begin
        op = dgf_pkg::mul_req(64'(bi_r), dgf_pkg::GLIDE_K, KQ32);  op_next = dgf_pkg::ST_R1;
      end
      dgf_pkg::ST_R1: begin
        op = dgf_pkg::mul_req(fbi_r, wx_r, KF);  op_next = dgf_pkg::ST_R2;
      end
      dgf_pkg::ST_R2: begin
        op = dgf_pkg::mul_req(fbr_r, wy_r, KF);  op_next = dgf_pkg::ST_G1;
      end
      dgf_pkg::ST_G1: begin
        op = dgf_pkg::mul_req(64'(br_r), ex_r, KF);  op_next = dgf_pkg::ST_G2;
      end
      dgf_pkg::ST_G2: begin
        op = dgf_pkg::mul_req(64'(bi_r), ey_r, KF);  op_next = dgf_pkg::ST_G3;
      end
      dgf_pkg::ST_G3: begin
        op = dgf_pkg::mul_req(64'(br_r), ey_r, KF);  op_next = dgf_pkg::ST_G4;
      end
      dgf_pkg::ST_G4: begin
        op = dgf_pkg::mul_req(64'(bi_r), ex_r, KF);  op_next = dgf_pkg::ST_FGR;
      end
      dgf_pkg::ST_FGR: begin
        op = dgf_pkg::mul_req(gr_r, dgf_pkg::GLIDE_K, KQ32);  op_next = dgf_pkg::ST_FGI;
      end
      dgf_pkg::ST_FGI: begin
        op = dgf_pkg::mul_req(gi_r, dgf_pkg::GLIDE_K, KQ32);  op_next = dgf_pkg::ST_P1;
      end
      dgf_pkg::ST_P1: begin
        op = dgf_pkg::mul_req(wx_r, fgr_r, KF);  op_next = dgf_pkg::ST_P2;
      end
      dgf_pkg::ST_P2: begin
        op = dgf_pkg::mul_req(wy_r, fgi_r, KF);  op_next = dgf_pkg::ST_P3;
      end
      dgf_pkg::ST_P3: begin
        op = dgf_pkg::mul_req(wx_r, fgi_r, KF);  op_next = dgf_pkg::ST_P4;
      end
      dgf_pkg::ST_P4: begin
        op = dgf_pkg::mul_req(wy_r, fgr_r, KF);  op_next = dgf_pkg::ST_ACC;
      end
      dgf_pkg::ST_K1: begin
        op = dgf_pkg::mul_req(64'(ydiff), 64'(sin2_r), KF1);  op_next = dgf_pkg::ST_K2;
      end
      dgf_pkg::ST_K2: begin
        op = dgf_pkg::mul_req(64'(xy_r), 64'(cos2_r), KF);  op_next = dgf_pkg::ST_FX;
      end
      dgf_pkg::ST_FX: begin
        op = dgf_pkg::mul_req(64'(br_r), kf_r, KF);  op_next = dgf_pkg::ST_FY;
      end
      dgf_pkg::ST_FY: begin
        op = dgf_pkg::mul_req(64'(bi_r), kf_r, KF);  op_next = dgf_pkg::ST_EMIT;
      end
      default: is_op = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    issued_nxt = issued_r;
    req        = op;
    req.start  = 1'b0;
    emit       = 1'b0;
    unique case (st_r)
      dgf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          st_nxt = in_tuser ? dgf_pkg::ST_CHK : (in_tlast ? dgf_pkg::ST_K1 : dgf_pkg::ST_IDLE);
        end
      end
      dgf_pkg::ST_CHK: st_nxt = far ? dgf_pkg::ST_NSQX : dgf_pkg::ST_DSQX;
      dgf_pkg::ST_ACC: st_nxt = skip_st;
      dgf_pkg::ST_EMIT: begin
        if (!out_valid_r) begin
          emit   = 1'b1;
          st_nxt = dgf_pkg::ST_IDLE;
        end
      end
      default: begin
        if (is_op) begin
          if (!issued_r) begin
            req.start  = 1'b1;
            issued_nxt = 1'b1;
          end else if (rsp.done) begin
            issued_nxt = 1'b0;
            st_nxt     = op_next;
          end
        end
      end
    endcase
    out_valid_nxt = (out_valid_r & ~out_tready) | emit;
  end

  assign in_tready = (st_r == dgf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dgf_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      xx_r        <= '0;
      yy_r        <= '0;
      xy_r        <= '0;
    end else begin
      st_r        <= st_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        xx_r <= '0;
        yy_r <= '0;
        xy_r <= '0;
      end else if (st_r == dgf_pkg::ST_ACC) begin
        xx_r <= dgf_pkg::sum_add(xx_r, dgf_pkg::clamp_int(66'(two) - 66'(q_r)));
        yy_r <= dgf_pkg::sum_add(yy_r, dgf_pkg::clamp_int(66'(two) + 66'(q_r)));
        xy_r <= dgf_pkg::sum_add(xy_r, p_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      px_r   <= in_tdata[31:0];
      py_r   <= in_tdata[63:32];
      last_r <= in_tlast;
    end
    if (emit) begin
      ox_r <= fx_r;
      oy_r <= fy_r;
    end
    if (cap) begin
      unique case (st_r)
        dgf_pkg::ST_DSQX, dgf_pkg::ST_NSQX: sqx_r <= rsp.result;
        dgf_pkg::ST_DSQY, dgf_pkg::ST_NSQY: sqy_r <= rsp.result;
        dgf_pkg::ST_NXY: nxy_r <= rsp.result;
        dgf_pkg::ST_WX:  wx_r  <= rsp.result;
        dgf_pkg::ST_WY:  wy_r  <= rsp.result;
        dgf_pkg::ST_EX:  ex_r  <= rsp.result;
        dgf_pkg::ST_EY:  ey_r  <= rsp.result;
        dgf_pkg::ST_FBR: fbr_r <= rsp.result;
        dgf_pkg::ST_FBI: fbi_r <= rsp.result;
        dgf_pkg::ST_R1, dgf_pkg::ST_G1, dgf_pkg::ST_G3, dgf_pkg::ST_P1, dgf_pkg::ST_P3,
        dgf_pkg::ST_K1: t1_r <= rsp.result;
        dgf_pkg::ST_R2:  rephi_r <= dgf_pkg::clamp_int(66'(t1_r) - 66'(rsp.result));
        dgf_pkg::ST_G2:  gr_r <= dgf_pkg::clamp_int(66'(br_r) + 66'(t1_r) + 66'(rsp.result));
        dgf_pkg::ST_G4:  gi_r <= dgf_pkg::clamp_int(66'(bi_r) + 66'(t1_r) - 66'(rsp.result));
        dgf_pkg::ST_FGR: fgr_r <= rsp.result;
        dgf_pkg::ST_FGI: fgi_r <= rsp.result;
        dgf_pkg::ST_P2:  p_r <= dgf_pkg::clamp_int(66'(t1_r) - 66'(rsp.result));
        dgf_pkg::ST_P4:  q_r <= dgf_pkg::clamp_int(66'(t1_r) + 66'(rsp.result));
        dgf_pkg::ST_K2:  kf_r <= dgf_pkg::clamp_int(66'(t1_r) + 66'(rsp.result));
        dgf_pkg::ST_FX:  fx_r <= dgf_pkg::sat32(rsp.result);
        dgf_pkg::ST_FY:  fy_r <= dgf_pkg::sat32(rsp.result);
        default: begin
        end
      endcase
    end
  end

  dgf_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oy_r, ox_r};

endmodule

// ===== tb/dislocation_glide_force_unit_tb.sv =====
`timescale 1ns / 1ps

module dislocation_glide_force_unit_tb;

  localparam int FB          = dgf_pkg::FRAC_BITS_DEF;
  localparam int IDLE_WAIT   = 2000;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 104;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        src;
    logic        last;
    logic        typed;
    logic [31:0] fx;
    logic [31:0] fy;
  } point_row_t;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
  } glide_force_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [63:0]                in_tdata;
  logic                       in_tuser;
  logic                       in_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [63:0]                out_tdata;
  logic                       cfg_we;
  logic [dgf_pkg::ADDR_W-1:0] cfg_addr;
  logic [dgf_pkg::CFG_W-1:0]  cfg_wdata;

  dislocation_glide_force_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the block: registers and the three stress sums
  logic [31:0]        glide_reg [dgf_pkg::REG_COUNT];
  logic signed [63:0] sum_xx, sum_yy, sum_xy;
  glide_force_t       force_fifo[$];
  int                 errors;
  int                 points_sent;
  int                 forces_seen;
  int                 sources_sent;
  int                 stall_cnt;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp_lim(input logic signed [65:0] v);
    if (v > 66'(dgf_pkg::INT_LIM)) return dgf_pkg::INT_LIM;
    if (v < -66'(dgf_pkg::INT_LIM)) return -dgf_pkg::INT_LIM;
    return 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp_sum(input logic signed [65:0] v);
    if (v > 66'(dgf_pkg::SUM_LIM)) return 64'(dgf_pkg::SUM_LIM);
    if (v < -66'(dgf_pkg::SUM_LIM)) return -64'(dgf_pkg::SUM_LIM);
    return 64'(v);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // round(a*b / 2^k) half away from zero, saturated
  function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b, input int k);
    logic [127:0] p;
    logic         neg;
    neg = a[63] != b[63];
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = (p + (128'd1 << (k - 1))) >> k;
    if (p > 128'(dgf_pkg::INT_LIM)) p = 128'(dgf_pkg::INT_LIM);
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic [63:0] frac_div(input logic [63:0] a, input int k,
                                           input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, a} << k) / {64'd0, den};
    if (q > 128'(dgf_pkg::INT_LIM)) q = 128'(dgf_pkg::INT_LIM);
    return q[63:0];
  endfunction

  function automatic logic [31:0] reg_mask(input int idx, input logic [31:0] v);
    if (idx == dgf_pkg::REG_CUTOFF) return {1'b0, v[30:0]};
    if (idx == dgf_pkg::REG_COS_TWO || idx == dgf_pkg::REG_SIN_TWO) return {14'd0, v[17:0]};
    return v;
  endfunction

  function automatic logic signed [63:0] angle_val(input logic [31:0] v);
    logic signed [17:0] a;
    a = v[17:0];
    return a;
  endfunction

  task automatic add_stress(input logic signed [63:0] px, input logic signed [63:0] py);
    logic signed [63:0] br, bi, dx, dy, wx, wy, ex, ey;
    logic signed [63:0] fbr, fbi, rephi, gr, gi, fgr, fgi, p, q, two;
    logic [63:0]        ax, ay, c, nx, ny, nx2, ny2, n2, t;
    int                 s;
    br = $signed(glide_reg[dgf_pkg::REG_BURGERS_RE]);
    bi = $signed(glide_reg[dgf_pkg::REG_BURGERS_IM]);
    dx = $signed(glide_reg[dgf_pkg::REG_TARGET_X]) - px;
    dy = $signed(glide_reg[dgf_pkg::REG_TARGET_Y]) - py;
    c  = {33'd0, glide_reg[dgf_pkg::REG_CUTOFF][30:0]};
    ax = abs64(dx);
    ay = abs64(dy);
    if (!(ax > c || ay > c) && ax * ax + ay * ay <= c * c) return;
    s = 0;
    while ((ax >> s) >= 64'h80000000 || (ay >> s) >= 64'h80000000) s++;
    nx  = ax >> s;
    ny  = ay >> s;
    nx2 = nx * nx;
    ny2 = ny * ny;
    n2  = nx2 + ny2;
    if (n2 == 0) return;
    sources_sent++;
    t  = frac_div(nx, 2 * FB - s, n2);
    wx = dx[63] ? -$signed(t) : $signed(t);
    t  = frac_div(ny, 2 * FB - s, n2);
    wy = dy[63] ? -$signed(t) : $signed(t);
    if (nx2 >= ny2) ex = $signed(frac_div(nx2 - ny2, FB, n2));
    else ex = -$signed(frac_div(ny2 - nx2, FB, n2));
    t  = frac_div(2 * nx * ny, FB, n2);
    ey = (dx[63] != dy[63]) ? -$signed(t) : $signed(t);

    fbr   = scaled_mul(br, dgf_pkg::GLIDE_K, 32);
    fbi   = scaled_mul(bi, dgf_pkg::GLIDE_K, 32);
    rephi = clamp_lim(66'(scaled_mul(fbi, wx, FB)) - 66'(scaled_mul(fbr, wy, FB)));
    gr = clamp_lim(66'(br) + 66'(scaled_mul(br, ex, FB)) + 66'(scaled_mul(bi, ey, FB)));
    gi = clamp_lim(66'(bi) + 66'(scaled_mul(br, ey, FB)) - 66'(scaled_mul(bi, ex, FB)));
    fgr = scaled_mul(gr, dgf_pkg::GLIDE_K, 32);
    fgi = scaled_mul(gi, dgf_pkg::GLIDE_K, 32);
    p = clamp_lim(66'(scaled_mul(wx, fgr, FB)) - 66'(scaled_mul(wy, fgi, FB)));
    q = clamp_lim(66'(scaled_mul(wx, fgi, FB)) + 66'(scaled_mul(wy, fgr, FB)));
    two    = clamp_lim(66'(rephi) * 2);
    sum_xx = clamp_sum(66'(sum_xx) + 66'(clamp_lim(66'(two) - 66'(q))));
    sum_yy = clamp_sum(66'(sum_yy) + 66'(clamp_lim(66'(two) + 66'(q))));
    sum_xy = clamp_sum(66'(sum_xy) + 66'(p));
  endtask

  // sets has_res when the point closes the domain, with the force in res
  task automatic predict_point(input point_row_t pt, output bit has_res,
                               output glide_force_t res);
    logic signed [63:0] kf;
    has_res = 0;
    res     = '{32'd0, 32'd0};
    if (pt.src) add_stress($signed(pt.x), $signed(pt.y));
    if (!pt.last) return;
    kf = clamp_lim(66'(scaled_mul(sum_yy - sum_xx,
                                  angle_val(glide_reg[dgf_pkg::REG_SIN_TWO]), FB + 1))
                 + 66'(scaled_mul(sum_xy, angle_val(glide_reg[dgf_pkg::REG_COS_TWO]), FB)));
    res.fx  = clamp32(scaled_mul($signed(glide_reg[dgf_pkg::REG_BURGERS_RE]), kf, FB));
    res.fy  = clamp32(scaled_mul($signed(glide_reg[dgf_pkg::REG_BURGERS_IM]), kf, FB));
    has_res = 1;
    sum_xx  = 0;
    sum_yy  = 0;
    sum_xy  = 0;
  endtask

  // write enable drops again when the next item is driven
  task automatic write_reg(input logic [dgf_pkg::ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < dgf_pkg::REG_COUNT) glide_reg[idx] = reg_mask(idx, val);
  endtask

  task automatic send_point(input point_row_t pt);
    int           gap;
    bit           has_res;
    glide_force_t res;
    cfg_we <= 1'b0;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pt.y, pt.x};
    in_tuser  <= pt.src;
    in_tlast  <= pt.last;
    do @(posedge clk); while (!in_tready);
    points_sent++;
    predict_point(pt, has_res, res);
    if (has_res) begin
      if (pt.typed) begin
        res.fx = pt.fx;
        res.fy = pt.fy;
      end
      force_fifo = {force_fifo, res};
    end
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (force_fifo.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_span(input int bits);
    logic [31:0] v;
    v = $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic logic [31:0] rand_angle(input int phase);
    case (phase % 4)
      0: return 32'd65536;
      1: return -32'sd65536;
      2: return 32'd0;
      default: return $urandom_range(0, 131072) - 65536;
    endcase
  endfunction

  function automatic point_row_t rand_point();
    point_row_t pt;
    int         span;
    span = $urandom_range(4, 24);
    if ($urandom_range(0, 9) < 7) begin
      pt.x = glide_reg[dgf_pkg::REG_TARGET_X] + rand_span(span);
      pt.y = glide_reg[dgf_pkg::REG_TARGET_Y] + rand_span(span);
    end else begin
      pt.x = $urandom();
      pt.y = $urandom();
    end
    pt.src   = $urandom_range(0, 3) != 0;
    pt.last  = 1'b0;
    pt.typed = 1'b0;
    pt.fx    = 32'd0;
    pt.fy    = 32'd0;
    return pt;
  endfunction

  localparam int DIR_ROWS  = 17;
  localparam int DIR_SPLIT = 4;
  point_row_t dir_rows [DIR_ROWS];

  initial begin
    // reset registers: zero burgers vector, every force is zero
    dir_rows[0]  = '{32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[1]  = '{32'h7fffffff, 32'h80000000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[2]  = '{32'h80000000, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[3]  = '{32'h00000001, 32'h00000001, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0};
    // b = (1.0, -0.5), target at origin, cutoff 2.0
    dir_rows[4]  = '{32'h00000000, 32'h00000000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[5]  = '{32'h00010000, 32'h00000000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[6]  = '{32'h00020000, 32'h00000000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[7]  = '{32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0};
    dir_rows[8]  = '{32'h00030000, 32'h00010000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[9]  = '{32'hfffd0000, 32'h00050000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[10] = '{32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0};
    dir_rows[11] = '{32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[12] = '{32'h80000000, 32'h80000000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[13] = '{32'h80000000, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0};
    dir_rows[14] = '{32'h7fffffff, 32'h80000000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0};
    dir_rows[15] = '{32'h00040000, 32'hfffc0000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0};
    dir_rows[16] = '{32'h00090000, 32'h00000001, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0};
  end

  // result side: random back-pressure and in-order compare
  initial begin
    glide_force_t want;
    int           stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      forces_seen++;
      if (force_fifo.size() == 0) begin
        $display("%0t: unexpected force item %h", $time, out_tdata);
        errors++;
      end else begin
        want = force_fifo.pop_front();
        if (out_tdata[31:0] !== want.fx) begin
          $display("%0t: force_x expected %h actual %h", $time, want.fx, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.fy) begin
          $display("%0t: force_y expected %h actual %h", $time, want.fy, out_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("dislocation_glide_force_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    point_row_t pt;
    int         dom_len;
    errors       = 0;
    points_sent  = 0;
    forces_seen  = 0;
    sources_sent = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    in_tlast     = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    foreach (glide_reg[i]) glide_reg[i] = 32'd0;
    glide_reg[dgf_pkg::REG_COS_TWO] = 32'd65536;
    sum_xx = 0;
    sum_yy = 0;
    sum_xy = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == DIR_SPLIT) begin
        drain_and_idle();
        write_reg(dgf_pkg::REG_BURGERS_RE, 32'h00010000);
        write_reg(dgf_pkg::REG_BURGERS_IM, 32'hffff8000);
        write_reg(dgf_pkg::REG_TARGET_X, 32'd0);
        write_reg(dgf_pkg::REG_TARGET_Y, 32'd0);
        write_reg(dgf_pkg::REG_CUTOFF, 32'h00020000);
        // index past the register file is dropped
        write_reg(3'd7, 32'h12345678);
      end
      send_point(dir_rows[r]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_idle();
      case (ph)
        1: begin
          write_reg(dgf_pkg::REG_BURGERS_RE, 32'h7fffffff);
          write_reg(dgf_pkg::REG_BURGERS_IM, 32'h80000000);
        end
        2: begin
          write_reg(dgf_pkg::REG_BURGERS_RE, 32'h80000000);
          write_reg(dgf_pkg::REG_BURGERS_IM, 32'h7fffffff);
        end
        default: begin
          write_reg(dgf_pkg::REG_BURGERS_RE, rand_span($urandom_range(8, 20)));
          write_reg(dgf_pkg::REG_BURGERS_IM, rand_span($urandom_range(8, 20)));
        end
      endcase
      write_reg(dgf_pkg::REG_TARGET_X, (ph == 3) ? 32'h7fffffff : $urandom());
      write_reg(dgf_pkg::REG_TARGET_Y, (ph == 3) ? 32'h80000000 : $urandom());
      case (ph)
        4:       write_reg(dgf_pkg::REG_CUTOFF, 32'h7fffffff);
        5:       write_reg(dgf_pkg::REG_CUTOFF, 32'd0);
        default: write_reg(dgf_pkg::REG_CUTOFF, $urandom_range(0, 1 << 20));
      endcase
      write_reg(dgf_pkg::REG_COS_TWO, rand_angle(ph));
      write_reg(dgf_pkg::REG_SIN_TWO, rand_angle(ph + 1));
      if (ph % 3 == 0) write_reg(3'd7, $urandom());

      // domains of a few points, each closed by a last point
      for (int n = 0; n < PHASE_ITEMS; ) begin
        dom_len = $urandom_range(1, 8);
        for (int j = 0; j < dom_len; j++) begin
          pt = rand_point();
          pt.last = (j == dom_len - 1);
          send_point(pt);
        end
        n += dom_len;
      end
    end

    in_tvalid <= 1'b0;
    while (force_fifo.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("items sent %0d, counted sources %0d, forces checked %0d over %0d settings",
             points_sent, sources_sent, forces_seen, PHASES + 2);
    $display("mismatches %0d", errors);
    if (errors == 0 && force_fifo.size() == 0) begin
      $display("dislocation_glide_force_unit_tb: PASS");
    end else begin
      $display("dislocation_glide_force_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
